[rtl/vmt_pkg.sv]
// ----------------------------------------------------------------------------
// vmt_pkg
// Shared types and constants for the 4x4 row-vector matrix transform.
// ----------------------------------------------------------------------------
package vmt_pkg;

  localparam int NUM_LANES = 4;
  localparam int NUM_CELLS = 4;
  localparam int IDX_W     = 2;
  localparam int OUT_W     = 32;
  localparam int FIELD_W   = 32;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_XFORM = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } ctl_t;

endpackage

[rtl/vmt_cell.sv]
// ----------------------------------------------------------------------------
// vmt_cell
// One matrix row: holds four elements, multiplies the matching vector
// component by them and adds the products to the passing partial sums.
// ----------------------------------------------------------------------------
module vmt_cell import vmt_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int ACC_W     = 66,
  parameter int CELL_IDX  = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ctl_t                        in_ctl,
  input  logic signed [WORD_BITS-1:0] in_value,
  input  logic signed [WORD_BITS-1:0] in_vec [NUM_LANES],
  input  logic signed [ACC_W-1:0]     in_acc [NUM_LANES],
  output logic                        out_valid,
  input  logic                        out_ready,
  output ctl_t                        out_ctl,
  output logic signed [WORD_BITS-1:0] out_value,
  output logic signed [WORD_BITS-1:0] out_vec [NUM_LANES],
  output logic signed [ACC_W-1:0]     out_acc [NUM_LANES]
);

  localparam int PROD_W = 2 * WORD_BITS;

  logic signed [WORD_BITS-1:0] row_r [NUM_LANES];

  logic                        a_valid_r;
  ctl_t                        a_ctl_r;
  logic signed [WORD_BITS-1:0] a_value_r;
  logic signed [WORD_BITS-1:0] a_vec_r [NUM_LANES];
  logic signed [ACC_W-1:0]     a_acc_r [NUM_LANES];
  logic signed [PROD_W-1:0]    a_prod_r [NUM_LANES];
  logic signed [PROD_W-1:0]    prod_nxt [NUM_LANES];

  logic                        b_valid_r;
  ctl_t                        b_ctl_r;
  logic signed [WORD_BITS-1:0] b_value_r;
  logic signed [WORD_BITS-1:0] b_vec_r [NUM_LANES];
  logic signed [ACC_W-1:0]     b_acc_r [NUM_LANES];

  logic a_ready;
  logic b_ready;
  logic take;
  logic load_hit;

  assign b_ready  = !b_valid_r || out_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;
  assign take     = in_valid && a_ready;
  assign load_hit = take && (in_ctl.mode == MODE_LOAD) && (in_ctl.row == IDX_W'(CELL_IDX));

  always_comb begin
    for (int j = 0; j < NUM_LANES; j++) begin
      prod_nxt[j] = in_vec[CELL_IDX] * row_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NUM_LANES; j++) begin
        row_r[j] <= '0;
      end
    end else if (load_hit) begin
      row_r[in_ctl.col] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_ctl_r   <= in_ctl;
      a_value_r <= in_value;
      a_vec_r   <= in_vec;
      a_acc_r   <= in_acc;
      a_prod_r  <= prod_nxt;
    end
    if (a_valid_r && b_ready) begin
      b_ctl_r   <= a_ctl_r;
      b_value_r <= a_value_r;
      b_vec_r   <= a_vec_r;
      for (int j = 0; j < NUM_LANES; j++) begin
        b_acc_r[j] <= a_acc_r[j] + ACC_W'(a_prod_r[j]);
      end
    end
  end

  assign out_valid = b_valid_r;
  assign out_ctl   = b_ctl_r;
  assign out_value = b_value_r;
  assign out_vec   = b_vec_r;
  assign out_acc   = b_acc_r;

endmodule

[rtl/vmt_sat.sv]
// ----------------------------------------------------------------------------
// vmt_sat
// Output stage: drops load beats, scales the sums down and clamps each
// component to the word range, then holds the result until it is taken.
// ----------------------------------------------------------------------------
module vmt_sat import vmt_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16,
  parameter int ACC_W     = 66
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  ctl_t                     in_ctl,
  input  logic signed [ACC_W-1:0]  in_acc [NUM_LANES],
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [OUT_W-1:0]  out_comp [NUM_LANES],
  output logic                     out_saturated
);

  localparam int HI_W = ACC_W - WORD_BITS + 1;
  localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic                     valid_r;
  logic signed [OUT_W-1:0]  comp_r [NUM_LANES];
  logic                     sat_r;
  logic signed [OUT_W-1:0]  comp_nxt [NUM_LANES];
  logic                     sat_nxt;
  logic signed [ACC_W-1:0]  shifted;
  logic        [HI_W-1:0]   hi;
  logic signed [WORD_BITS-1:0] clamped;
  logic                     fits;
  logic                     hold_ok;
  logic                     is_xform;

  assign is_xform = in_ctl.mode == MODE_XFORM;
  assign hold_ok  = !valid_r || out_ready;
  assign in_ready = !is_xform || hold_ok;

  always_comb begin
    sat_nxt = 1'b0;
    shifted = '0;
    hi      = '0;
    fits    = 1'b1;
    clamped = '0;
    for (int j = 0; j < NUM_LANES; j++) begin
      shifted = in_acc[j] >>> FRAC_BITS;
      hi      = shifted[ACC_W-1:WORD_BITS-1];
      fits    = (&hi) || !(|hi);
      if (fits) begin
        clamped = shifted[WORD_BITS-1:0];
      end else if (shifted[ACC_W-1]) begin
        clamped = W_MIN;
      end else begin
        clamped = W_MAX;
      end
      sat_nxt     = sat_nxt || !fits;
      comp_nxt[j] = OUT_W'(clamped);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (hold_ok) begin
      valid_r <= in_valid && is_xform;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && is_xform && hold_ok) begin
      comp_r <= comp_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_comp      = comp_r;
  assign out_saturated = sat_r;

endmodule

[rtl/vec4_mat4_transform.sv]
// ----------------------------------------------------------------------------
// vec4_mat4_transform
// Row vector times 4x4 signed fixed-point matrix, built as a chain of four
// row cells followed by a scaling and clamping output stage.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    in_mode, in_elem_*, in_vec_*
//   out      output     out_valid/out_ready  out_x..out_w, out_saturated
//
// One beat is accepted per cycle while in_ready is high, loads and transforms alike.
// A transform result passes through two stages per row cell (multiply,
// then add) and one output stage, the first of them loaded at the
// accepting edge.
// A load updates its row when the beat passes that row's cell, so it takes
// effect in order with the transforms around it.
// Reset empties the chain and clears the matrix to zero.
// Bubbles close up under a stall; in_ready falls only when every stage holds
// a beat and the output result is not being taken.
// ----------------------------------------------------------------------------
module vec4_mat4_transform import vmt_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  logic [IDX_W-1:0]         in_elem_row,
  input  logic [IDX_W-1:0]         in_elem_col,
  input  logic signed [FIELD_W-1:0] in_elem_value,
  input  logic signed [FIELD_W-1:0] in_vec_x,
  input  logic signed [FIELD_W-1:0] in_vec_y,
  input  logic signed [FIELD_W-1:0] in_vec_z,
  input  logic signed [FIELD_W-1:0] in_vec_w,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [OUT_W-1:0] out_x,
  output logic signed [OUT_W-1:0] out_y,
  output logic signed [OUT_W-1:0] out_z,
  output logic signed [OUT_W-1:0] out_w,
  output logic                     out_saturated
);

  localparam int ACC_W = 2 * WORD_BITS + 2;
  localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic                        ch_valid [NUM_CELLS+1];
  logic                        ch_ready [NUM_CELLS+1];
  ctl_t                        ch_ctl   [NUM_CELLS+1];
  logic signed [WORD_BITS-1:0] ch_value [NUM_CELLS+1];
  logic signed [WORD_BITS-1:0] ch_vec   [NUM_CELLS+1][NUM_LANES];
  logic signed [ACC_W-1:0]     ch_acc   [NUM_CELLS+1][NUM_LANES];
  logic signed [OUT_W-1:0]     comp     [NUM_LANES];

  assign ch_valid[0]     = in_valid;
  assign in_ready        = ch_ready[0];
  assign ch_ctl[0].mode  = in_mode;
  assign ch_ctl[0].row   = in_elem_row;
  assign ch_ctl[0].col   = in_elem_col;
  assign ch_value[0]     = in_elem_value[WORD_BITS-1:0];
  assign ch_vec[0][0]    = in_vec_x[WORD_BITS-1:0];
  assign ch_vec[0][1]    = in_vec_y[WORD_BITS-1:0];
  assign ch_vec[0][2]    = in_vec_z[WORD_BITS-1:0];
  assign ch_vec[0][3]    = in_vec_w[WORD_BITS-1:0];
  assign ch_acc[0]       = '{default: '0};

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    vmt_cell #(
      .WORD_BITS (WORD_BITS),
      .ACC_W     (ACC_W),
      .CELL_IDX  (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ch_valid[k]),
      .in_ready  (ch_ready[k]),
      .in_ctl    (ch_ctl[k]),
      .in_value  (ch_value[k]),
      .in_vec    (ch_vec[k]),
      .in_acc    (ch_acc[k]),
      .out_valid (ch_valid[k+1]),
      .out_ready (ch_ready[k+1]),
      .out_ctl   (ch_ctl[k+1]),
      .out_value (ch_value[k+1]),
      .out_vec   (ch_vec[k+1]),
      .out_acc   (ch_acc[k+1])
    );
  end

  vmt_sat #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .ACC_W     (ACC_W)
  ) u_sat (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (ch_valid[NUM_CELLS]),
    .in_ready      (ch_ready[NUM_CELLS]),
    .in_ctl        (ch_ctl[NUM_CELLS]),
    .in_acc        (ch_acc[NUM_CELLS]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_comp      (comp),
    .out_saturated (out_saturated)
  );

  assign out_x = comp[0];
  assign out_y = comp[1];
  assign out_z = comp[2];
  assign out_w = comp[3];

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("Result present right after reset.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("Input stalled while the output side is free.");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_x == OUT_W'(W_MAX) || out_x == OUT_W'(W_MIN) ||
       out_y == OUT_W'(W_MAX) || out_y == OUT_W'(W_MIN) ||
       out_z == OUT_W'(W_MAX) || out_z == OUT_W'(W_MIN) ||
       out_w == OUT_W'(W_MAX) || out_w == OUT_W'(W_MIN)))
    else $error("Saturation flagged without a clamped component.");

endmodule

[tb/sv/vmt_tb_pkg.sv]
// ----------------------------------------------------------------------------
// vmt_tb_pkg
// Tracks the matrix that the transform block should hold and the vertex
// results it owes. Loads update the tracked matrix in beat order. Each
// transform beat queues the exact, floored and clamped product of the vector
// with that matrix, and every output beat is compared against the oldest one.
// ----------------------------------------------------------------------------
package vmt_tb_pkg;
  import vmt_pkg::*;

  localparam int FRAC = 16;
  localparam longint LANE_MAX = 64'sd2147483647;
  localparam longint LANE_MIN = -64'sd2147483648;

  typedef logic signed [FIELD_W-1:0] word_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t w;
    logic  sat;
  } vertex_t;

  class vertex_tracker;
    word_t   matrix [16];
    vertex_t owed [$];
    int      errors;
    int      results_seen;

    function new();
      foreach (matrix[k]) matrix[k] = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function vertex_t transform(word_t vx, word_t vy, word_t vz, word_t vw);
      word_t              v [4];
      word_t              lane [4];
      logic signed [65:0] acc;
      logic signed [49:0] scaled;
      vertex_t            r;
      v[0] = vx;
      v[1] = vy;
      v[2] = vz;
      v[3] = vw;
      r.sat = 1'b0;
      for (int j = 0; j < 4; j++) begin
        acc = '0;
        for (int i = 0; i < 4; i++) begin
          acc = acc + v[i] * matrix[i*4+j];
        end
        scaled = 50'(acc >>> FRAC);
        if (scaled > LANE_MAX) begin
          lane[j] = word_t'(LANE_MAX);
          r.sat = 1'b1;
        end else if (scaled < LANE_MIN) begin
          lane[j] = word_t'(LANE_MIN);
          r.sat = 1'b1;
        end else begin
          lane[j] = scaled[FIELD_W-1:0];
        end
      end
      r.x = lane[0];
      r.y = lane[1];
      r.z = lane[2];
      r.w = lane[3];
      return r;
    endfunction

    function void note_input(logic mode, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                             word_t val, word_t vx, word_t vy, word_t vz, word_t vw);
      if (mode == MODE_LOAD) begin
        matrix[{row, col}] = val;
      end else begin
        owed.push_back(transform(vx, vy, vz, vw));
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction

    task report(string msg);
      $display("MISMATCH result %0d: %s", results_seen, msg);
      errors++;
    endtask

    task check_output(vertex_t got);
      vertex_t want;
      word_t   g [4];
      word_t   e [4];
      string   names [4];
      names = '{"out_x", "out_y", "out_z", "out_w"};
      if (owed.size() == 0) begin
        report("output beat with no transform outstanding");
      end else begin
        want = owed.pop_front();
        g = '{got.x, got.y, got.z, got.w};
        e = '{want.x, want.y, want.z, want.w};
        for (int k = 0; k < 4; k++) begin
          if (g[k] !== e[k]) begin
            report($sformatf("%s = %h, want %h", names[k], g[k], e[k]));
          end
        end
        if (got.sat !== want.sat) begin
          report($sformatf("out_saturated = %b, want %b", got.sat, want.sat));
        end
      end
      results_seen++;
    endtask
  endclass

endpackage

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives vec4_mat4_transform with directed corner beats (floor rounding,
// clamping both ways, four-product worst-case accumulation) and then a long random
// mix of loads and transforms, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import vmt_pkg::*;
  import vmt_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam word_t W_MAX      = 32'sh7fffffff;
  localparam word_t W_MIN      = 32'sh80000000;
  localparam word_t W_ONE      = 32'sh00010000;
  localparam int    RAND_ITEMS = 800;
  localparam int    DRAIN_WAIT = 20;
  localparam int    QUIET_MAX  = 1000;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_ready;
  logic             in_mode       = MODE_LOAD;
  logic [IDX_W-1:0] in_elem_row   = '0;
  logic [IDX_W-1:0] in_elem_col   = '0;
  word_t            in_elem_value = '0;
  word_t            in_vec_x      = '0;
  word_t            in_vec_y      = '0;
  word_t            in_vec_z      = '0;
  word_t            in_vec_w      = '0;
  logic             out_valid;
  logic             out_ready     = 1'b0;
  word_t            out_x;
  word_t            out_y;
  word_t            out_z;
  word_t            out_w;
  logic             out_saturated;

  vertex_tracker sb;
  bit            steady_tail = 1'b0;
  int            quiet_cycles = 0;

  wire in_fire  = rst_n && in_valid && in_ready;
  wire out_fire = rst_n && out_valid && out_ready;

  vec4_mat4_transform uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_elem_row   (in_elem_row),
    .in_elem_col   (in_elem_col),
    .in_elem_value (in_elem_value),
    .in_vec_x      (in_vec_x),
    .in_vec_y      (in_vec_y),
    .in_vec_z      (in_vec_z),
    .in_vec_w      (in_vec_w),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_w         (out_w),
    .out_saturated (out_saturated)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    if (in_fire) begin
      sb.note_input(in_mode, in_elem_row, in_elem_col, in_elem_value,
                    in_vec_x, in_vec_y, in_vec_z, in_vec_w);
    end
    if (out_fire) begin
      sb.check_output('{out_x, out_y, out_z, out_w, out_saturated});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_MAX) @(posedge clk);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!steady_tail && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return W_MAX;
      1:       return W_MIN;
      2:       return '0;
      3:       return ($urandom_range(0, 1) != 0) ? -32'sd1 : 32'sd1;
      4, 5, 6: return word_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      default: return word_t'($urandom());
    endcase
  endfunction

  task automatic drive_beat(logic mode, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                            word_t val, word_t vx, word_t vy, word_t vz, word_t vw);
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_elem_row   <= row;
    in_elem_col   <= col;
    in_elem_value <= val;
    in_vec_x      <= vx;
    in_vec_y      <= vy;
    in_vec_z      <= vz;
    in_vec_w      <= vw;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load(int row, int col, word_t val);
    drive_beat(MODE_LOAD, IDX_W'(row), IDX_W'(col), val,
               rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  task automatic xform(word_t vx, word_t vy, word_t vz, word_t vw);
    drive_beat(MODE_XFORM, IDX_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 3)),
               rand_word(), vx, vy, vz, vw);
  endtask

  task automatic hold_off(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    bit gaps;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    xform(W_MAX, W_MIN, -32'sd1, 32'sd1);
    for (int k = 0; k < 4; k++) load(k, k, W_ONE);
    xform(W_MAX, W_MIN, -32'sd1, '0);
    load(3, 0, W_MAX);
    xform('0, '0, '0, W_MAX);
    xform('0, '0, '0, W_MIN);
    load(3, 0, W_MIN);
    xform('0, '0, '0, W_MIN);
    xform(32'sd1, '0, '0, -32'sd1);
    load(0, 1, 32'sd1);
    xform(-32'sd1, '0, '0, '0);
    for (int k = 0; k < 4; k++) load(k, 2, W_MIN);
    xform(W_MIN, W_MIN, W_MIN, W_MIN);
    xform(W_MAX, W_MAX, W_MAX, W_MAX);
    xform('0, '0, '0, '0);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) wait_drained();
      if (n == RAND_ITEMS - 100) steady_tail = 1'b1;
      gaps = !steady_tail && ((n / 100) % 2 == 0);
      if (gaps && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 15));
      if ($urandom_range(0, 9) < 4) begin
        load($urandom_range(0, 3), $urandom_range(0, 3), rand_word());
      end else begin
        xform(rand_word(), rand_word(), rand_word(), rand_word());
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d transform results never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
